FILE: rtl/gbee_pkg.sv
`timescale 1ns / 1ps
// Shared types, command codes, configuration indexes and row transform functions for the glyph bitmap edit engine.
// Depends on nothing; used by gbee_row_cell, gbee_head and glyph_bitmap_edit_engine_core.
package gbee_pkg;

	// Row width is fixed by the pixel word of one row
	localparam int ROW_W = 32;

	// Edit command codes
	localparam logic [3:0] ACT_CUR_LEFT  = 4'd0;
	localparam logic [3:0] ACT_CUR_RIGHT = 4'd1;
	localparam logic [3:0] ACT_CUR_UP    = 4'd2;
	localparam logic [3:0] ACT_CUR_DOWN  = 4'd3;
	localparam logic [3:0] ACT_TOGGLE    = 4'd4;
	localparam logic [3:0] ACT_SHL       = 4'd5;
	localparam logic [3:0] ACT_SHR       = 4'd6;
	localparam logic [3:0] ACT_SHU       = 4'd7;
	localparam logic [3:0] ACT_SHD       = 4'd8;
	localparam logic [3:0] ACT_MIRROR    = 4'd9;
	localparam logic [3:0] ACT_LOAD      = 4'd10;
	localparam logic [3:0] ACT_READ      = 4'd11;

	// Configuration register indexes
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// Control handed from the sequencer to the head of the row chain
	typedef struct packed {
		logic       pass1;   // read-only sweep: capture boundary rows
		logic       pass2;   // editing sweep: rows are rewritten
		logic [3:0] action;
		logic [5:0] w;       // effective width, 1..32
		logic [5:0] h;       // effective height
		logic [5:0] k;       // index of the row now at the head
		logic [4:0] cx;
		logic [4:0] cy;
		logic [4:0] ri;
	} head_ctrl_t;

	// Mask of the columns in use
	function automatic logic [ROW_W-1:0] col_mask(input logic [5:0] w);
		return {ROW_W{1'b1}} >> (6'd32 - w);
	endfunction

	// Rotate left within w columns; seg has no bits at or above w
	function automatic logic [ROW_W-1:0] rot_left(input logic [ROW_W-1:0] seg,
		input logic [5:0] w);
		logic [ROW_W-1:0] low;
		low = {{(ROW_W-1){1'b0}}, seg[0]};
		return ((seg >> 1) | (low << (w - 6'd1))) & col_mask(w);
	endfunction

	// Rotate right within w columns
	function automatic logic [ROW_W-1:0] rot_right(input logic [ROW_W-1:0] seg,
		input logic [5:0] w);
		return ((seg << 1) | (seg >> (w - 6'd1))) & col_mask(w);
	endfunction

	// Reverse the w columns in use
	function automatic logic [ROW_W-1:0] mirror(input logic [ROW_W-1:0] seg,
		input logic [5:0] w);
		logic [ROW_W-1:0] rev;
		for (int i = 0; i < ROW_W; i++) begin
			rev[i] = seg[ROW_W-1-i];
		end
		return rev >> (6'd32 - w);
	endfunction

endpackage

FILE: rtl/gbee_row_cell.sv
`timescale 1ns / 1ps
// One cell of the row chain: holds one bitmap row and takes its neighbour's row when stepping.
// Depends on gbee_pkg for the row width.
module gbee_row_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [gbee_pkg::ROW_W-1:0] din,
	output logic [gbee_pkg::ROW_W-1:0] q
);

	logic [gbee_pkg::ROW_W-1:0] row_q;

	// Image clears on reset; row moves one cell along on each step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (step) begin
			row_q <= din;
		end
	end

	assign q = row_q;

endmodule

FILE: rtl/gbee_head.sv
`timescale 1ns / 1ps
// Head of the row chain: edits the row leaving cell 0 and feeds it back to the far end.
// Depends on gbee_pkg for the control struct, command codes and row functions.
module gbee_head (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gbee_pkg::head_ctrl_t       ctrl,
	input  logic [gbee_pkg::ROW_W-1:0] head_in,   // row in cell 0
	input  logic [gbee_pkg::ROW_W-1:0] next_in,   // row in cell 1, still unedited
	input  logic [gbee_pkg::ROW_W-1:0] load_data,
	output logic [gbee_pkg::ROW_W-1:0] head_out
);

	logic [gbee_pkg::ROW_W-1:0] first_q;   // original row 0
	logic [gbee_pkg::ROW_W-1:0] last_q;    // original row h-1
	logic [gbee_pkg::ROW_W-1:0] prev_q;    // original row k-1
	logic [gbee_pkg::ROW_W-1:0] m;
	logic [gbee_pkg::ROW_W-1:0] seg;
	logic [gbee_pkg::ROW_W-1:0] new_seg;
	logic [gbee_pkg::ROW_W-1:0] edited;
	logic                       in_area;

	// Boundary rows for the vertical rotations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			last_q  <= '0;
			prev_q  <= '0;
		end else begin
			if (ctrl.pass1 && ctrl.k == 6'd0) begin
				first_q <= head_in;
			end
			if (ctrl.pass1 && ctrl.k == ctrl.h - 6'd1) begin
				last_q <= head_in;
			end
			if (ctrl.pass2) begin
				prev_q <= head_in;
			end
		end
	end

	// Per-row edit
	always_comb begin
		m       = gbee_pkg::col_mask(ctrl.w);
		seg     = head_in & m;
		in_area = ctrl.k < ctrl.h;
		case (ctrl.action)
			gbee_pkg::ACT_SHL:    new_seg = gbee_pkg::rot_left(seg, ctrl.w);
			gbee_pkg::ACT_SHR:    new_seg = gbee_pkg::rot_right(seg, ctrl.w);
			gbee_pkg::ACT_MIRROR: new_seg = gbee_pkg::mirror(seg, ctrl.w);
			gbee_pkg::ACT_SHU:
				new_seg = ((ctrl.k == ctrl.h - 6'd1) ? first_q : next_in) & m;
			gbee_pkg::ACT_SHD:
				new_seg = ((ctrl.k == 6'd0) ? last_q : prev_q) & m;
			default:              new_seg = seg;
		endcase
		edited = in_area ? ((head_in & ~m) | new_seg) : head_in;
		if (ctrl.action == gbee_pkg::ACT_TOGGLE && ctrl.k == {1'b0, ctrl.cy}) begin
			edited = edited ^ ({{(gbee_pkg::ROW_W-1){1'b0}}, 1'b1} << ctrl.cx);
		end
		if (ctrl.action == gbee_pkg::ACT_LOAD && ctrl.k == {1'b0, ctrl.ri}) begin
			edited = load_data;
		end
		head_out = ctrl.pass2 ? edited : head_in;
	end

endmodule

FILE: rtl/glyph_bitmap_edit_engine_core.sv
`timescale 1ns / 1ps
// Top level of the glyph bitmap edit engine: command sequencer, cursor and result register.
// Depends on gbee_pkg, gbee_row_cell and gbee_head.

// The bitmap lives in a ring of row cells, one row per cell (min(MAX_HEIGHT,32) cells).
// Every command is carried out by sweeping the ring twice past the head cell, which
// sees one row per cycle: the first sweep only notes the boundary rows that the
// vertical shifts need, the second rewrites each row in place. Before the sweeps, a
// cursor left outside a newly narrowed area is brought back in range, one subtraction
// per step (at most 31 steps). The result is loaded into the output register once that
// register is free. One command is in work at a time; a new one is accepted while the
// previous result still waits in the output register.
module glyph_bitmap_edit_engine_core #(
	parameter int MAX_WIDTH  = 32,
	parameter int MAX_HEIGHT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data,
	// command channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  action,
	input  logic [4:0]  row_index,
	input  logic [31:0] row_data,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] row_out,
	output logic [4:0]  cursor_col,
	output logic [4:0]  cursor_row,
	output logic        cursor_pixel
);

	localparam int NROWS = (MAX_HEIGHT < 32) ? MAX_HEIGHT : 32;
	localparam int WLIM  = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;
	localparam int KW    = $clog2(NROWS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WRAP  = 3'd1;
	localparam logic [2:0] ST_PASS1 = 3'd2;
	localparam logic [2:0] ST_PASS2 = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]  state_q;
	logic [KW-1:0] cnt_q;
	logic [5:0]  width_q, height_q;
	logic [5:0]  w_eff, h_eff;
	logic [4:0]  cx_q, cy_q;
	logic [3:0]  act_q;
	logic [4:0]  ri_q;
	logic [31:0] data_q;
	logic [31:0] row_cap_q;
	logic        pix_cap_q;
	logic        out_valid_q;
	logic [31:0] row_out_q;
	logic [4:0]  col_out_q, rowc_out_q;
	logic        pix_out_q;
	logic        step;
	logic        cnt_last;
	logic        cx_hi, cy_hi;
	logic        out_load;
	gbee_pkg::head_ctrl_t ctrl;

	logic [gbee_pkg::ROW_W-1:0] rows [NROWS];
	logic [gbee_pkg::ROW_W-1:0] head_out;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 6'd8;
			height_q <= 6'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				gbee_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				gbee_pkg::CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective dimensions: zero acts as one, saturate at the limit
	always_comb begin
		w_eff = (width_q == 6'd0) ? 6'd1 : width_q;
		if (w_eff > 6'(WLIM)) w_eff = 6'(WLIM);
		h_eff = (height_q == 6'd0) ? 6'd1 : height_q;
		if (h_eff > 6'(NROWS)) h_eff = 6'(NROWS);
	end

	assign step     = (state_q == ST_PASS1) || (state_q == ST_PASS2);
	assign cnt_last = cnt_q == KW'(NROWS - 1);
	assign cx_hi    = {1'b0, cx_q} >= w_eff;
	assign cy_hi    = {1'b0, cy_q} >= h_eff;
	assign in_stall = state_q != ST_IDLE;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// Command sequencer and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					// bring cursor back inside the area, one subtraction per cycle
					if (cx_hi) cx_q <= 5'({1'b0, cx_q} - w_eff);
					if (cy_hi) cy_q <= 5'({1'b0, cy_q} - h_eff);
					if (!cx_hi && !cy_hi) begin
						case (act_q)
							gbee_pkg::ACT_CUR_LEFT:
								cx_q <= (cx_q == 5'd0) ? 5'(w_eff - 6'd1) : cx_q - 5'd1;
							gbee_pkg::ACT_CUR_RIGHT:
								cx_q <= ({1'b0, cx_q} + 6'd1 == w_eff) ? 5'd0 : cx_q + 5'd1;
							gbee_pkg::ACT_CUR_UP:
								cy_q <= (cy_q == 5'd0) ? 5'(h_eff - 6'd1) : cy_q - 5'd1;
							gbee_pkg::ACT_CUR_DOWN:
								cy_q <= ({1'b0, cy_q} + 6'd1 == h_eff) ? 5'd0 : cy_q + 5'd1;
							default: ;
						endcase
						cnt_q   <= '0;
						state_q <= ST_PASS1;
					end
				end
				ST_PASS1: begin
					cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
					if (cnt_last) state_q <= ST_PASS2;
				end
				ST_PASS2: begin
					cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
					if (cnt_last) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command payload held for the whole transaction
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			act_q  <= action;
			ri_q   <= row_index;
			data_q <= row_data;
		end
	end

	// Result capture as the edited rows pass the head
	always_ff @(posedge clk) begin
		if (state_q == ST_PASS1) begin
			row_cap_q <= '0;
		end
		if (state_q == ST_PASS2 && 5'(cnt_q) == ri_q) begin
			row_cap_q <= head_out;
		end
		if (state_q == ST_PASS2 && 5'(cnt_q) == cy_q) begin
			pix_cap_q <= head_out[cx_q];
		end
		if (out_load) begin
			row_out_q  <= row_cap_q;
			col_out_q  <= cx_q;
			rowc_out_q <= cy_q;
			pix_out_q  <= pix_cap_q;
		end
	end

	// Head control
	always_comb begin
		ctrl.pass1  = state_q == ST_PASS1;
		ctrl.pass2  = state_q == ST_PASS2;
		ctrl.action = act_q;
		ctrl.w      = w_eff;
		ctrl.h      = h_eff;
		ctrl.k      = 6'(cnt_q);
		ctrl.cx     = cx_q;
		ctrl.cy     = cy_q;
		ctrl.ri     = ri_q;
	end

	// Ring of row cells: each steps towards cell 0, the head feeds the far end
	for (genvar i = 0; i < NROWS; i++) begin : g_cell
		gbee_row_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.step  (step),
			.din   ((i == NROWS - 1) ? head_out : rows[(i + 1) % NROWS]),
			.q     (rows[i])
		);
	end

	gbee_head u_head (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.head_in  (rows[0]),
		.next_in  (rows[1]),
		.load_data(data_q),
		.head_out (head_out)
	);

	assign out_valid    = out_valid_q;
	assign row_out      = row_out_q;
	assign cursor_col   = col_out_q;
	assign cursor_row   = rowc_out_q;
	assign cursor_pixel = pix_out_q;

endmodule
